### design/assert_macros.svh
// Assertion macros shared by the bencode checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BPBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BPBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpbc_pkg.sv
// Types, codes and constants of the bencode prefix budget checker.
package bpbc_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int CNT_W       = LENGTH_BITS + 1;
  localparam int NEED_W      = CNT_W + 1;
  localparam int TOTAL_W     = NEED_W + 1;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(1) << LENGTH_BITS;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LENGTH = 2'd0;

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SYNTAX   = 3'd1,
    ST_BUDGET   = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FR_LIST   = 2'd0,
    FR_DICT_K = 2'd1,
    FR_DICT_V = 2'd2
  } frame_t;

  typedef enum logic [3:0] {
    PH_NONE     = 4'b0001,
    PH_INT      = 4'b0010,
    PH_STR_LEN  = 4'b0100,
    PH_STR_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [LENGTH_BITS-1:0] good_length;
    logic                   verdict_ok;
    logic                   verdict_valid;
  } out_word_t;

  typedef struct packed {
    logic   en;
    logic   clear;
    logic   push;
    logic   pop;
    frame_t top_nxt;
  } stk_ctl_t;

  function automatic logic [1:0] close_cost(frame_t f);
    return (f == FR_DICT_K) ? 2'd3 : 2'd1;
  endfunction

endpackage

### design/bencode_prefix_budget_checker.sv
// Bencode prefix budget checker: top level, per-byte parse and budget check.
// Result: each accepted byte word's result word is registered and valid in the cycle after it.
// Throughput: one byte per cycle while the output is not stalled; the byte step is a single pass over
// the frame-stack top registers, parse state and one budget compare.
// Reset: synchronous rst_n clears parse state, stack level and max_length;
// the last byte of a document returns all state but max_length to reset.
`include "assert_macros.svh"

module bencode_prefix_budget_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  bpbc_pkg::in_word_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output bpbc_pkg::out_word_t                    out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bpbc_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [bpbc_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [bpbc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int LB     = bpbc_pkg::LENGTH_BITS;
  localparam int CNT_W  = bpbc_pkg::CNT_W;
  localparam int NEED_W = bpbc_pkg::NEED_W;
  localparam int TOT_W  = bpbc_pkg::TOTAL_W;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int COST_W = $clog2(3 * STACK_DEPTH + 1);

  // configuration
  logic [LB-1:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '0;
    end else if (psel && penable && pwrite && (paddr == bpbc_pkg::ADDR_MAX_LENGTH)) begin
      max_len_r <= pwdata[LB-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == bpbc_pkg::ADDR_MAX_LENGTH) ?
                  bpbc_pkg::CFG_DATA_W'(max_len_r) : '0;

  // handshake
  logic in_fire;
  logic out_valid_r;
  bpbc_pkg::out_word_t out_data_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // parse state
  bpbc_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        digits_r, digits_nxt;
  logic              nlz_r, nlz_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              llz_r, llz_nxt;
  logic              begun_r, begun_nxt;
  logic              closed_r, closed_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [LB-1:0]     bp_r;
  logic              failed_r, failed_nxt;

  bpbc_pkg::stk_ctl_t stk_ctl;
  bpbc_pkg::frame_t   stk_top, stk_below, top_eff, top_nxt;
  logic [LVL_W-1:0]   stk_level, lvl_eff, lvl_nxt;

  bpbc_frame_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .below (stk_below),
    .level (stk_level)
  );

  logic [7:0]          ch;
  logic                is_digit;
  logic [3:0]          dval;
  logic [CNT_W+3:0]    cnt_mul;
  logic [CNT_W-1:0]    cnt_dec;
  bpbc_pkg::status_t   st, st_fin;
  logic                push, pop, start, done;
  logic [NEED_W-1:0]   need;
  logic [LB:0]         pos;
  logic [TOT_W-1:0]    total;
  logic                commit;

  assign ch       = in_data.char_byte;
  assign is_digit = (ch >= bpbc_pkg::CH_ZERO) && (ch <= bpbc_pkg::CH_NINE);
  assign dval     = ch[3:0];
  assign cnt_mul  = ({4'b0, cnt_r} << 3) + ({4'b0, cnt_r} << 1) + (CNT_W+4)'(dval);
  assign cnt_dec  = (cnt_r != '0) ? (cnt_r - CNT_W'(1)) : '0;

  always_comb begin
    st         = bpbc_pkg::ST_OK;
    phase_nxt  = phase_r;
    digits_nxt = digits_r;
    nlz_nxt    = nlz_r;
    cnt_nxt    = cnt_r;
    llz_nxt    = llz_r;
    begun_nxt  = begun_r;
    closed_nxt = closed_r;
    cost_nxt   = cost_r;
    push       = 1'b0;
    pop        = 1'b0;
    start      = 1'b0;
    done       = 1'b0;
    top_nxt    = stk_top;
    if (closed_r) begin
      st = bpbc_pkg::ST_SYNTAX;
    end else begin
      unique case (phase_r)
        bpbc_pkg::PH_INT: begin
          if (is_digit) begin
            if (nlz_r) begin
              st = bpbc_pkg::ST_SYNTAX;
            end else begin
              if ((ch == bpbc_pkg::CH_ZERO) && (digits_r == 2'd0)) begin
                nlz_nxt = 1'b1;
              end
              if (digits_r != 2'd3) begin
                digits_nxt = digits_r + 2'd1;
              end
            end
          end else if ((ch == bpbc_pkg::CH_E) && (digits_r != 2'd0)) begin
            phase_nxt = bpbc_pkg::PH_NONE;
            done      = 1'b1;
          end else begin
            st = bpbc_pkg::ST_SYNTAX;
          end
        end
        bpbc_pkg::PH_STR_LEN: begin
          if (is_digit) begin
            if (llz_r) begin
              st = bpbc_pkg::ST_SYNTAX;
            end else if (cnt_mul > (CNT_W+4)'(bpbc_pkg::CNT_CAP)) begin
              cnt_nxt = bpbc_pkg::CNT_CAP;
            end else begin
              cnt_nxt = cnt_mul[CNT_W-1:0];
            end
          end else if (ch == bpbc_pkg::CH_COLON) begin
            if (cnt_r == '0) begin
              phase_nxt = bpbc_pkg::PH_NONE;
              done      = 1'b1;
            end else begin
              phase_nxt = bpbc_pkg::PH_STR_BODY;
            end
          end else begin
            st = bpbc_pkg::ST_SYNTAX;
          end
        end
        bpbc_pkg::PH_STR_BODY: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            phase_nxt = bpbc_pkg::PH_NONE;
            done      = 1'b1;
          end
        end
        bpbc_pkg::PH_NONE: begin
          if (stk_level == '0) begin
            if (begun_r) begin
              st = bpbc_pkg::ST_SYNTAX;
            end else begin
              begun_nxt = 1'b1;
              start     = 1'b1;
            end
          end else if (ch == bpbc_pkg::CH_E) begin
            if ((stk_top == bpbc_pkg::FR_LIST) || (stk_top == bpbc_pkg::FR_DICT_K)) begin
              cost_nxt = cost_r - COST_W'(bpbc_pkg::close_cost(stk_top));
              pop      = 1'b1;
              done     = 1'b1;
            end else begin
              st = bpbc_pkg::ST_SYNTAX;
            end
          end else begin
            start = 1'b1;
          end
        end
        default: st = bpbc_pkg::ST_SYNTAX;
      endcase
    end

    if (start) begin
      if (ch == bpbc_pkg::CH_I) begin
        phase_nxt  = bpbc_pkg::PH_INT;
        digits_nxt = 2'd0;
        nlz_nxt    = 1'b0;
      end else if ((ch == bpbc_pkg::CH_L) || (ch == bpbc_pkg::CH_D)) begin
        if (stk_level >= LVL_W'(STACK_DEPTH)) begin
          st = bpbc_pkg::ST_OVERFLOW;
        end else begin
          push     = 1'b1;
          top_nxt  = (ch == bpbc_pkg::CH_D) ? bpbc_pkg::FR_DICT_K : bpbc_pkg::FR_LIST;
          cost_nxt = cost_r + COST_W'(bpbc_pkg::close_cost(top_nxt));
        end
      end else if (is_digit) begin
        phase_nxt = bpbc_pkg::PH_STR_LEN;
        cnt_nxt   = CNT_W'(dval);
        llz_nxt   = (ch == bpbc_pkg::CH_ZERO);
      end else begin
        st = bpbc_pkg::ST_SYNTAX;
      end
    end

    // a finished item flips the enclosing dict between key and value
    lvl_eff = pop ? (stk_level - LVL_W'(1)) : stk_level;
    top_eff = pop ? stk_below : stk_top;
    if (pop) begin
      top_nxt = top_eff;
    end
    if (done) begin
      if (lvl_eff == '0) begin
        closed_nxt = 1'b1;
      end else begin
        case (top_eff)
          bpbc_pkg::FR_DICT_K: begin
            cost_nxt = cost_nxt - COST_W'(2);
            top_nxt  = bpbc_pkg::FR_DICT_V;
          end
          bpbc_pkg::FR_DICT_V: begin
            cost_nxt = cost_nxt + COST_W'(2);
            top_nxt  = bpbc_pkg::FR_DICT_K;
          end
          default: top_nxt = top_eff;
        endcase
      end
    end
    lvl_nxt = push ? (stk_level + LVL_W'(1)) : lvl_eff;
  end

  // fewest characters still needed to close the document
  always_comb begin
    need = '0;
    if (!closed_nxt) begin
      unique case (phase_nxt)
        bpbc_pkg::PH_NONE: begin
          if (!begun_nxt) begin
            need = NEED_W'(2);
          end else if (lvl_nxt != '0) begin
            case (top_nxt)
              bpbc_pkg::FR_DICT_V: need = NEED_W'(cost_nxt) + NEED_W'(2);
              bpbc_pkg::FR_DICT_K: need = NEED_W'(cost_nxt) - NEED_W'(2);
              default:             need = NEED_W'(cost_nxt);
            endcase
          end
        end
        bpbc_pkg::PH_INT:
          need = NEED_W'(cost_nxt) + ((digits_nxt == 2'd0) ? NEED_W'(2) : NEED_W'(1));
        bpbc_pkg::PH_STR_LEN:
          need = NEED_W'(cost_nxt) + NEED_W'(cnt_nxt) + NEED_W'(1);
        bpbc_pkg::PH_STR_BODY:
          need = NEED_W'(cost_nxt) + NEED_W'(cnt_nxt);
        default: need = '0;
      endcase
    end
  end

  assign pos   = {1'b0, bp_r} + (LB+1)'(1);
  assign total = TOT_W'(pos) + TOT_W'(need);

  always_comb begin
    if (failed_r) begin
      st_fin = bpbc_pkg::ST_IGNORED;
    end else if ((st == bpbc_pkg::ST_OK) && (total > TOT_W'(max_len_r))) begin
      st_fin = bpbc_pkg::ST_BUDGET;
    end else begin
      st_fin = st;
    end
  end

  assign commit     = !failed_r && (st_fin == bpbc_pkg::ST_OK);
  assign failed_nxt = failed_r || (st_fin != bpbc_pkg::ST_OK);

  assign stk_ctl.en      = in_fire && (commit || in_data.is_last);
  assign stk_ctl.clear   = in_data.is_last;
  assign stk_ctl.push    = push;
  assign stk_ctl.pop     = pop;
  assign stk_ctl.top_nxt = top_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bpbc_pkg::PH_NONE;
      digits_r <= 2'd0;
      nlz_r    <= 1'b0;
      cnt_r    <= '0;
      llz_r    <= 1'b0;
      begun_r  <= 1'b0;
      closed_r <= 1'b0;
      cost_r   <= '0;
      bp_r     <= '0;
      failed_r <= 1'b0;
    end else if (in_fire) begin
      if (in_data.is_last) begin
        phase_r  <= bpbc_pkg::PH_NONE;
        digits_r <= 2'd0;
        nlz_r    <= 1'b0;
        cnt_r    <= '0;
        llz_r    <= 1'b0;
        begun_r  <= 1'b0;
        closed_r <= 1'b0;
        cost_r   <= '0;
        bp_r     <= '0;
        failed_r <= 1'b0;
      end else begin
        if (commit) begin
          phase_r  <= phase_nxt;
          digits_r <= digits_nxt;
          nlz_r    <= nlz_nxt;
          cnt_r    <= cnt_nxt;
          llz_r    <= llz_nxt;
          begun_r  <= begun_nxt;
          closed_r <= closed_nxt;
          cost_r   <= cost_nxt;
          bp_r     <= pos[LB-1:0];
        end
        failed_r <= failed_nxt;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.status        <= st_fin;
      out_data_r.good_length   <= commit ? pos[LB-1:0] : bp_r;
      out_data_r.verdict_ok    <= in_data.is_last && !failed_nxt && closed_nxt;
      out_data_r.verdict_valid <= in_data.is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BPBC_ASSERT_NXT(a_last_clears, in_fire && in_data.is_last, (stk_level == '0) && !failed_r && (bp_r == '0), "state not cleared after last byte")
  `BPBC_ASSERT_IMP(a_cost_empty, stk_level == '0, cost_r == '0, "closing cost without open frames")
  `BPBC_ASSERT_NXT(a_ignored, in_fire && failed_r, out_data.status == bpbc_pkg::ST_IGNORED, "byte after failure not ignored")
  `BPBC_ASSERT_IMP(a_good_len, out_valid_r && (out_data.status == bpbc_pkg::ST_OK) && !out_data.verdict_valid, out_data.good_length == bp_r, "good length out of step with position")

endmodule

### design/bpbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/bpbc_frame_stack.sv
// Frame stack: top and second entries in registers, deeper entries in RAM.
`include "assert_macros.svh"

module bpbc_frame_stack #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpbc_pkg::stk_ctl_t         ctl,
  output bpbc_pkg::frame_t           top,
  output bpbc_pkg::frame_t           below,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [LVL_W-1:0]  level_r, level_nxt;
  bpbc_pkg::frame_t  top_r, sec_r, byp_data_r, third;
  logic              byp_r;
  logic              wr_en;
  logic [LVL_W-1:0]  wr_lvl, rd_lvl;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [1:0]        rd_data;

  always_comb begin
    level_nxt = level_r;
    if (ctl.en) begin
      if (ctl.clear) begin
        level_nxt = '0;
      end else if (ctl.push) begin
        level_nxt = level_r + LVL_W'(1);
      end else if (ctl.pop) begin
        level_nxt = level_r - LVL_W'(1);
      end
    end
  end

  // second entry spills to RAM on push; RAM read tracks the entry under second
  assign wr_en   = ctl.en && !ctl.clear && ctl.push && (level_r >= LVL_W'(2));
  assign wr_lvl  = level_r - LVL_W'(2);
  assign wr_addr = wr_lvl[ADDR_W-1:0];
  assign rd_lvl  = level_nxt - LVL_W'(3);
  assign rd_addr = rd_lvl[ADDR_W-1:0];

  bpbc_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (sec_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entry under the second one: RAM data, or the word written in the last cycle
  assign third = byp_r ? byp_data_r : bpbc_pkg::frame_t'(rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      byp_r   <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= sec_r;
    if (ctl.en) begin
      top_r <= ctl.top_nxt;
      if (ctl.push) begin
        sec_r <= top_r;
      end else if (ctl.pop) begin
        sec_r <= third;
      end
    end
  end

  assign top   = top_r;
  assign below = sec_r;
  assign level = level_r;

  `BPBC_ASSERT_IMP(a_no_push_full, ctl.en && !ctl.clear && ctl.push, level_r < LVL_W'(DEPTH), "push on full stack")
  `BPBC_ASSERT_IMP(a_no_pop_empty, ctl.en && !ctl.clear && ctl.pop, level_r != '0, "pop on empty stack")

endmodule
